// File: rtl/otsu_threshold_8bit_core_macros.svh
// Assertion macros for the checker file of the threshold core.
`ifndef OTSU_THRESHOLD_8BIT_CORE_MACROS_SVH
`define OTSU_THRESHOLD_8BIT_CORE_MACROS_SVH

// Same-cycle implication, sampled on clk_i and held off while rst_ni is low.
`define OTSU8_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i and held off while rst_ni is low.
`define OTSU8_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/otsu8_pkg.sv
// Shared constants and types of the Otsu threshold core.
package otsu8_pkg;

  localparam int BINS           = 256;
  localparam int BIN_W          = 8;
  localparam int COUNT_BITS_DEF = 21;
  localparam int SCORE_W        = 64;

  // Access to the histogram memory for one cycle.
  typedef struct packed {
    logic             inc;   // count one pixel into bin addr
    logic             clr;   // write zero to bin addr
    logic [BIN_W-1:0] addr;  // bin that is read this cycle
  } hist_cmd_t;

endpackage

// File: rtl/otsu_threshold_8bit_core.sv
// Top level of the Otsu threshold core: pixel intake, threshold sweep and result strobe.
//
// The core takes one 8-bit pixel per clock while busy_o is low: an item is
// accepted on a rising edge with start_i high and busy_o low, and pixel_i
// goes straight into a 256-bin histogram held in a single-port-read,
// single-port-write memory. Repeated grey levels on consecutive cycles are
// forwarded, so the intake rate is one item per cycle regardless of content.
// The item with last_i high ends the frame: busy_o rises on the next cycle,
// a drain state lets the final increment land, and then every bin is swept
// in order. Each bin is read, accumulated and checked in turn, and each
// threshold that leaves both classes non-empty is scored while the sweep
// waits on the shared score unit, which works by bit-serial multiplies over
// COUNT_BITS and 2*COUNT_BITS+8 bits and a 64-step division. The sweep also
// clears each bin as it reads it, so the next frame starts on an empty
// histogram. The result appears on threshold_o for exactly one cycle with
// valid_o high, in the same cycle that busy_o falls; there is no way to
// stall it, so the receiver must capture it then. After reset, busy_o stays
// high while every bin of the memory is cleared. Once a frame has counted
// 2^COUNT_BITS - 1 pixels, further pixels are dropped, though a last marker
// on a dropped pixel still ends the frame.
module otsu_threshold_8bit_core import otsu8_pkg::*; #(
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [BIN_W-1:0] pixel_i,
  input  logic             last_i,
  output logic             busy_o,
  output logic             valid_o,
  output logic [BIN_W-1:0] threshold_o
);

  localparam int CB = COUNT_BITS;
  localparam int SW = CB + BIN_W;

  typedef enum logic [2:0] {
    ST_INIT, ST_RUN, ST_DRAIN, ST_SRD, ST_SACC, ST_SCHK, ST_SWAIT
  } state_e;

  state_e             state_q;
  logic [BIN_W-1:0]   b_q;
  logic               busy_q;
  logic               valid_q;
  logic [BIN_W-1:0]   thr_q;
  logic [CB-1:0]      total_q;
  logic [SW-1:0]      sum_q;
  logic [CB-1:0]      n0_q;
  logic [SW-1:0]      s0_q;
  logic [SCORE_W-1:0] best_q;
  logic [BIN_W-1:0]   best_t_q;
  logic               sc_start_q;

  logic               accept;
  logic               cnt_ok;
  hist_cmd_t          hist_cmd;
  logic [CB-1:0]      rdata;
  logic [CB-1:0]      n0_acc;
  logic [SW-1:0]      prod;
  logic [SW-1:0]      s0_acc;
  logic               cand_ok;
  logic [CB-1:0]      n1;
  logic [SW-1:0]      s1;
  logic               sc_done;
  logic [SCORE_W-1:0] sc_score;

  assign accept = start_i && !busy_q;
  // The pixel count saturates at its maximum value, all ones.
  assign cnt_ok = (total_q != '1);

  // Pixel increments take the memory while the frame is coming in; the
  // sweep and the reset clear own it otherwise.
  always_comb begin
    hist_cmd.inc  = accept && cnt_ok;
    hist_cmd.addr = hist_cmd.inc ? pixel_i : b_q;
    hist_cmd.clr  = (state_q == ST_INIT) || (state_q == ST_SRD);
  end

  otsu8_hist #(
    .CB (CB)
  ) u_hist (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cmd_i   (hist_cmd),
    .rdata_o (rdata)
  );

  // Running class-low totals once the bin just read is added in.
  assign n0_acc  = n0_q + rdata;
  assign prod    = SW'(rdata) * SW'(b_q);
  assign s0_acc  = s0_q + prod;

  // A threshold counts only when both classes hold pixels.
  assign cand_ok = (n0_q != '0) && (n0_q < total_q);
  assign n1      = total_q - n0_q;
  assign s1      = sum_q - s0_q;

  otsu8_score #(
    .CB (CB)
  ) u_score (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sc_start_q),
    .n0_i    (n0_q),
    .s0_i    (s0_q),
    .n1_i    (n1),
    .s1_i    (s1),
    .done_o  (sc_done),
    .score_o (sc_score)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_INIT;
      b_q        <= '0;
      busy_q     <= 1'b1;
      valid_q    <= 1'b0;
      thr_q      <= '0;
      total_q    <= '0;
      sum_q      <= '0;
      n0_q       <= '0;
      s0_q       <= '0;
      best_q     <= '0;
      best_t_q   <= '0;
      sc_start_q <= 1'b0;
    end else begin
      valid_q    <= 1'b0;
      sc_start_q <= 1'b0;
      unique case (state_q)
        ST_INIT: begin
          b_q <= b_q + 1'b1;
          if (b_q == '1) begin
            busy_q  <= 1'b0;
            state_q <= ST_RUN;
          end
        end
        ST_RUN: begin
          if (accept) begin
            if (cnt_ok) begin
              total_q <= total_q + 1'b1;
              sum_q   <= sum_q + SW'(pixel_i);
            end
            if (last_i) begin
              busy_q   <= 1'b1;
              best_q   <= '0;
              best_t_q <= '0;
              b_q      <= '0;
              n0_q     <= '0;
              s0_q     <= '0;
              state_q  <= ST_DRAIN;
            end
          end
        end
        ST_DRAIN: begin
          // The final increment is written back during this cycle.
          state_q <= ST_SRD;
        end
        ST_SRD: begin
          state_q <= ST_SACC;
        end
        ST_SACC: begin
          n0_q    <= n0_acc;
          s0_q    <= s0_acc;
          state_q <= ST_SCHK;
        end
        ST_SCHK: begin
          if (b_q == '1) begin
            // Top bin read and cleared: the frame is done.
            valid_q <= 1'b1;
            thr_q   <= best_t_q;
            total_q <= '0;
            sum_q   <= '0;
            busy_q  <= 1'b0;
            state_q <= ST_RUN;
          end else if (cand_ok) begin
            sc_start_q <= 1'b1;
            state_q    <= ST_SWAIT;
          end else begin
            b_q     <= b_q + 1'b1;
            state_q <= ST_SRD;
          end
        end
        ST_SWAIT: begin
          if (sc_done) begin
            // Strictly greater keeps the lowest threshold among ties.
            if (sc_score > best_q) begin
              best_q   <= sc_score;
              best_t_q <= b_q + 1'b1;
            end
            b_q     <= b_q + 1'b1;
            state_q <= ST_SRD;
          end
        end
        default: begin
          state_q <= ST_INIT;
        end
      endcase
    end
  end

  assign busy_o      = busy_q;
  assign valid_o     = valid_q;
  assign threshold_o = thr_q;

endmodule

// File: rtl/otsu8_hist.sv
// Histogram memory with a read-modify-write increment path and write forwarding.
module otsu8_hist import otsu8_pkg::*; #(
  parameter int CB = COUNT_BITS_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  hist_cmd_t     cmd_i,
  output logic [CB-1:0] rdata_o
);

  logic [CB-1:0]    mem_q [BINS];
  logic [CB-1:0]    rdata_q;
  logic             s1_v_q;
  logic [BIN_W-1:0] s1_a_q;
  logic             fw_v_q;
  logic [BIN_W-1:0] fw_a_q;
  logic [CB-1:0]    fw_d_q;
  logic [CB-1:0]    base;
  logic [CB-1:0]    inc_val;

  // A bin written on the edge that issued our read still shows its old value.
  assign base    = (fw_v_q && (fw_a_q == s1_a_q)) ? fw_d_q : rdata_q;
  assign inc_val = base + 1'b1;
  assign rdata_o = rdata_q;

  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[cmd_i.addr];
    if (s1_v_q) begin
      mem_q[s1_a_q] <= inc_val;
    end else if (cmd_i.clr) begin
      mem_q[cmd_i.addr] <= '0;
    end
    s1_a_q <= cmd_i.addr;
    fw_a_q <= s1_a_q;
    fw_d_q <= inc_val;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      fw_v_q <= 1'b0;
    end else begin
      s1_v_q <= cmd_i.inc;
      fw_v_q <= s1_v_q;
    end
  end

endmodule

// File: rtl/otsu8_score.sv
// Iterative unit for one candidate score: shift-add products, square and long division.
module otsu8_score import otsu8_pkg::*; #(
  parameter int CB = COUNT_BITS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic [CB-1:0]       n0_i,
  input  logic [CB+BIN_W-1:0] s0_i,
  input  logic [CB-1:0]       n1_i,
  input  logic [CB+BIN_W-1:0] s1_i,
  output logic                done_o,
  output logic [SCORE_W-1:0]  score_o
);

  localparam int SW    = CB + BIN_W;
  localparam int PW    = CB + SW;
  localparam int DW    = 2 * CB;
  localparam int SQW   = 2 * PW;
  localparam int XW    = (SQW > SCORE_W) ? SQW : SCORE_W + 1;
  localparam int HW    = XW - SCORE_W;
  localparam int CMW   = (HW > DW) ? HW : DW;
  localparam int MAXIT = (PW > SCORE_W) ? PW : SCORE_W;
  localparam int CNT_W = $clog2(MAXIT);

  typedef enum logic [2:0] {
    S_IDLE, S_MUL, S_SUB, S_SQ, S_OVF, S_DIV
  } state_e;

  state_e             state_q;
  logic [CNT_W-1:0]   cnt_q;
  logic [CB-1:0]      a0_q, a1_q;
  logic [PW-1:0]      ms1_q, ms0_q, p_q, q_q, dm_q;
  logic [DW-1:0]      mn1_q, dv_q, rem_q;
  logic [SQW-1:0]     dd_q, sq_q;
  logic [SCORE_W-1:0] lo_q, quo_q, score_q;
  logic               done_q;

  logic [PW-1:0]      diff;
  logic [XW-1:0]      xw;
  logic [HW-1:0]      hi;
  logic [DW:0]        trial, trial_sub;
  logic               fits;

  assign diff      = (p_q >= q_q) ? (p_q - q_q) : (q_q - p_q);
  assign xw        = XW'(sq_q);
  assign hi        = xw[XW-1:SCORE_W];
  assign trial     = {rem_q, lo_q[SCORE_W-1]};
  assign fits      = trial >= {1'b0, dv_q};
  assign trial_sub = trial - {1'b0, dv_q};

  assign done_o  = done_q;
  assign score_o = score_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      done_q  <= 1'b0;
      score_q <= '0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (start_i) begin
            a0_q    <= n0_i;
            a1_q    <= n1_i;
            ms1_q   <= PW'(s1_i);
            ms0_q   <= PW'(s0_i);
            mn1_q   <= DW'(n1_i);
            p_q     <= '0;
            q_q     <= '0;
            dv_q    <= '0;
            cnt_q   <= CNT_W'(CB - 1);
            state_q <= S_MUL;
          end
        end
        S_MUL: begin
          // Three products share the walk over the class counts.
          if (a0_q[0]) begin
            p_q  <= p_q + ms1_q;
            dv_q <= dv_q + mn1_q;
          end
          if (a1_q[0]) begin
            q_q <= q_q + ms0_q;
          end
          a0_q  <= a0_q >> 1;
          a1_q  <= a1_q >> 1;
          ms1_q <= ms1_q << 1;
          ms0_q <= ms0_q << 1;
          mn1_q <= mn1_q << 1;
          if (cnt_q == '0) begin
            state_q <= S_SUB;
          end else begin
            cnt_q <= cnt_q - 1'b1;
          end
        end
        S_SUB: begin
          dm_q    <= diff;
          dd_q    <= SQW'(diff);
          sq_q    <= '0;
          cnt_q   <= CNT_W'(PW - 1);
          state_q <= S_SQ;
        end
        S_SQ: begin
          if (dm_q[0]) begin
            sq_q <= sq_q + dd_q;
          end
          dm_q <= dm_q >> 1;
          dd_q <= dd_q << 1;
          if (cnt_q == '0) begin
            state_q <= S_OVF;
          end else begin
            cnt_q <= cnt_q - 1'b1;
          end
        end
        S_OVF: begin
          // The quotient needs more than 64 bits exactly when the upper part
          // of the square already reaches the divisor.
          if (CMW'(hi) >= CMW'(dv_q)) begin
            score_q <= '1;
            done_q  <= 1'b1;
            state_q <= S_IDLE;
          end else begin
            rem_q   <= DW'(hi);
            lo_q    <= xw[SCORE_W-1:0];
            quo_q   <= '0;
            cnt_q   <= CNT_W'(SCORE_W - 1);
            state_q <= S_DIV;
          end
        end
        S_DIV: begin
          rem_q <= fits ? trial_sub[DW-1:0] : trial[DW-1:0];
          quo_q <= {quo_q[SCORE_W-2:0], fits};
          lo_q  <= lo_q << 1;
          if (cnt_q == '0) begin
            score_q <= {quo_q[SCORE_W-2:0], fits};
            done_q  <= 1'b1;
            state_q <= S_IDLE;
          end else begin
            cnt_q <= cnt_q - 1'b1;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// File: rtl/otsu8_checker.sv
// Port-level assertions for the Otsu threshold core and their bind to the top level.
`include "otsu_threshold_8bit_core_macros.svh"

module otsu8_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic start_i,
  input logic last_i,
  input logic busy_o,
  input logic valid_o
);

  // A frame end always hands control to the sweep.
  `OTSU8_ASSERT_NXT(a_last_sets_busy, start_i && !busy_o && last_i, busy_o, "last item did not raise busy")
  // Ordinary items keep the intake open.
  `OTSU8_ASSERT_NXT(a_item_keeps_open, start_i && !busy_o && !last_i, !busy_o, "busy rose on a non-last item")
  // A result ends a sweep, so it comes exactly as busy falls.
  `OTSU8_ASSERT_IMP(a_result_ends_sweep, valid_o, $fell(busy_o), "result strobe without end of sweep")
  // The result strobe is never high on consecutive cycles.
  `OTSU8_ASSERT_NXT(a_result_single, valid_o, !valid_o, "result strobe longer than one cycle")

endmodule

bind otsu_threshold_8bit_core otsu8_checker u_otsu8_checker (.*);
